/* hdl/aoc_pkg.sv */
`timescale 1ns / 1ps

package aoc_pkg;

    localparam int COORD_W = 12;
    localparam int CFG_W   = 13;
    localparam int CHAN_W  = 8;
    localparam int NUM_COL = 3;
    localparam int WIN_W   = 16;

    localparam logic [CHAN_W-1:0] FULL = 8'd255;

    typedef enum logic [1:0] {
        REG_OFFSET_X       = 2'd0,
        REG_OFFSET_Y       = 2'd1,
        REG_OVERLAY_WIDTH  = 2'd2,
        REG_OVERLAY_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef logic [NUM_COL-1:0][CHAN_W-1:0] colour_t;

    typedef struct packed {
        logic                in_window;
        colour_t             base_col;
        logic [CHAN_W-1:0]   base_alpha;
        colour_t             over_col;
        logic [CHAN_W-1:0]   over_alpha;
    } pix_pass_t;

endpackage

/* hdl/alpha_over_composite.sv */
`timescale 1ns / 1ps

// Throughput: one pixel per clock; the whole pipeline holds while a result waits.
// Stages: window test and 8x8 products, 16x8 product, two /255 units in series.
// Reset (rst_n, async, active low): pipeline empties and window settings read 0; data registers are not reset.
module alpha_over_composite
    import aoc_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] row,
    input  logic [COORD_W-1:0] column,
    input  logic [CHAN_W-1:0]  base_red,
    input  logic [CHAN_W-1:0]  base_green,
    input  logic [CHAN_W-1:0]  base_blue,
    input  logic [CHAN_W-1:0]  base_alpha,
    input  logic [CHAN_W-1:0]  over_red,
    input  logic [CHAN_W-1:0]  over_green,
    input  logic [CHAN_W-1:0]  over_blue,
    input  logic [CHAN_W-1:0]  over_alpha,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAN_W-1:0]  out_red,
    output logic [CHAN_W-1:0]  out_green,
    output logic [CHAN_W-1:0]  out_blue,
    output logic [CHAN_W-1:0]  out_alpha,
    output logic               covered
);

    localparam int DEPTH = 6;
    localparam int LAST  = DEPTH - 1;

    logic                  adv;
    logic                  in_window;
    pix_pass_t             pass_in;
    pix_pass_t             pass_reg [DEPTH];
    logic [DEPTH-1:0]      valid_reg;
    logic [DEPTH-1:0]      valid_next;
    logic [15:0]           pa_next;
    logic [15:0]           pa_reg;
    logic [NUM_COL-1:0][15:0] pc_next;
    logic [NUM_COL-1:0][15:0] pc_reg [4];
    logic [NUM_COL-1:0][23:0] u_next;
    logic [NUM_COL-1:0][23:0] u_reg;
    logic [NUM_COL-1:0][15:0] under;
    logic [NUM_COL-1:0][16:0] sum;
    colour_t               blend;
    logic [CHAN_W-1:0]     alpha_q;
    logic [CHAN_W-1:0]     alpha_reg [3];
    pix_pass_t             last;
    logic                  opaque;

    assign adv      = !valid_reg[LAST] || out_ready;
    assign in_ready = adv;

    aoc_window #(
        .MAX_DIM (MAX_DIM)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row       (row),
        .column    (column),
        .in_window (in_window)
    );

    assign pass_in.in_window  = in_window;
    assign pass_in.base_col   = {base_blue, base_green, base_red};
    assign pass_in.base_alpha = base_alpha;
    assign pass_in.over_col   = {over_blue, over_green, over_red};
    assign pass_in.over_alpha = over_alpha;

    assign valid_next = {valid_reg[LAST-1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // stage 1 products
    assign pa_next = 16'(base_alpha) * 16'(FULL - over_alpha);
    always_comb
    begin
        for (int i = 0; i < NUM_COL; i++)
        begin
            pc_next[i] = 16'(over_alpha) * 16'(pass_in.over_col[i]);
            u_next[i]  = 24'(pa_reg) * 24'(pass_reg[0].base_col[i]);
            sum[i]     = 17'(pc_reg[3][i]) + 17'(under[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pass_reg[0] <= pass_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                pass_reg[k] <= pass_reg[k-1];
            end
            pa_reg    <= pa_next;
            pc_reg[0] <= pc_next;
            for (int k = 1; k < 4; k++)
            begin
                pc_reg[k] <= pc_reg[k-1];
            end
            u_reg        <= u_next;
            alpha_reg[0] <= pass_reg[2].over_alpha + alpha_q;
            alpha_reg[1] <= alpha_reg[0];
            alpha_reg[2] <= alpha_reg[1];
        end
    end

    aoc_div255 #(
        .IN_W  (16),
        .OUT_W (CHAN_W)
    ) u_div_alpha (
        .clk      (clk),
        .enable   (adv),
        .dividend (pa_reg),
        .quotient (alpha_q)
    );

    for (genvar g = 0; g < NUM_COL; g++)
    begin : g_chan
        aoc_div255 #(
            .IN_W  (24),
            .OUT_W (16)
        ) u_div_under (
            .clk      (clk),
            .enable   (adv),
            .dividend (u_reg[g]),
            .quotient (under[g])
        );

        aoc_div255 #(
            .IN_W  (17),
            .OUT_W (CHAN_W)
        ) u_div_out (
            .clk      (clk),
            .enable   (adv),
            .dividend (sum[g]),
            .quotient (blend[g])
        );
    end

    assign last      = pass_reg[LAST];
    assign opaque    = (last.over_alpha == FULL);
    assign out_valid = valid_reg[LAST];
    assign covered   = last.in_window;

    always_comb
    begin
        if (!last.in_window)
        begin
            out_red   = last.base_col[0];
            out_green = last.base_col[1];
            out_blue  = last.base_col[2];
            out_alpha = last.base_alpha;
        end
        else if (opaque)
        begin
            out_red   = last.over_col[0];
            out_green = last.over_col[1];
            out_blue  = last.over_col[2];
            out_alpha = last.over_alpha;
        end
        else
        begin
            out_red   = blend[0];
            out_green = blend[1];
            out_blue  = blend[2];
            out_alpha = alpha_reg[2];
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    a_alpha_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && covered) |-> (out_alpha >= last.over_alpha))
        else $error("composited alpha below overlay alpha");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted transfer not captured");

endmodule

/* hdl/aoc_window.sv */
`timescale 1ns / 1ps

module aoc_window
    import aoc_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [COORD_W-1:0] row,
    input  logic [COORD_W-1:0] column,
    output logic               in_window
);

    logic signed [CFG_W-1:0] offset_x_reg;
    logic signed [CFG_W-1:0] offset_y_reg;
    logic [CFG_W-1:0]        width_reg;
    logic [CFG_W-1:0]        height_reg;
    logic [CFG_W-1:0]        dim_clamped;
    logic signed [WIN_W-1:0] row_s;
    logic signed [WIN_W-1:0] col_s;
    logic signed [WIN_W-1:0] left;
    logic signed [WIN_W-1:0] top;
    logic signed [WIN_W-1:0] right;
    logic signed [WIN_W-1:0] bottom;

    // dimensions saturate at MAX_DIM
    assign dim_clamped = (32'(cfg_data) > 32'(MAX_DIM)) ? CFG_W'(MAX_DIM) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OFFSET_X:       offset_x_reg <= cfg_data;
                REG_OFFSET_Y:       offset_y_reg <= cfg_data;
                REG_OVERLAY_WIDTH:  width_reg    <= dim_clamped;
                REG_OVERLAY_HEIGHT: height_reg   <= dim_clamped;
                default: ;
            endcase
        end
    end

    assign row_s  = signed'({{(WIN_W-COORD_W){1'b0}}, row});
    assign col_s  = signed'({{(WIN_W-COORD_W){1'b0}}, column});
    assign left   = {{(WIN_W-CFG_W){offset_x_reg[CFG_W-1]}}, offset_x_reg};
    assign top    = {{(WIN_W-CFG_W){offset_y_reg[CFG_W-1]}}, offset_y_reg};
    assign right  = left + signed'({{(WIN_W-CFG_W){1'b0}}, width_reg});
    assign bottom = top + signed'({{(WIN_W-CFG_W){1'b0}}, height_reg});

    assign in_window = (row_s >= top) && (row_s < bottom) && (col_s >= left) && (col_s < right);

endmodule

/* hdl/aoc_div255.sv */
`timescale 1ns / 1ps

// two-stage floor(x/255): reciprocal estimate, then one-step correction
module aoc_div255
#(
    parameter int IN_W  = 24,
    parameter int OUT_W = 16
)
(
    input  logic             clk,
    input  logic             enable,
    input  logic [IN_W-1:0]  dividend,
    output logic [OUT_W-1:0] quotient
);

    localparam int Q_W   = IN_W - 7;
    localparam int P_W   = IN_W + 25;
    localparam logic [24:0] RECIP = 25'h1010101;

    logic [P_W-1:0]  prod;
    logic [Q_W-1:0]  q0_reg;
    logic [IN_W-1:0] x_reg;
    logic [IN_W:0]   q0_times;
    logic [IN_W:0]   rem;
    logic [Q_W-1:0]  q_next;
    logic [Q_W-1:0]  q_reg;

    assign prod = P_W'(dividend) * P_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            q0_reg <= prod[P_W-1:32];
            x_reg  <= dividend;
            q_reg  <= q_next;
        end
    end

    assign q0_times = {q0_reg, 8'd0} - (IN_W+1)'(q0_reg);
    assign rem      = (IN_W+1)'(x_reg) - q0_times;
    assign q_next   = (rem >= (IN_W+1)'(255)) ? q0_reg + Q_W'(1) : q0_reg;
    assign quotient = OUT_W'(q_reg);

endmodule
